FILE: hw/rtl/srrw_pkg.sv
// shared types and constants of the selective-repeat receive window
package srrw_pkg;

    // field widths
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned SEQ_W   = 32;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned REF_W   = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned WSIZE_W = 5;

    // configuration port
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 1;

    // defaults and limits
    localparam int unsigned WINDOW_DEFAULT = 16;
    localparam int unsigned MAX_PAYLOAD    = 1472;
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(16);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SEQ   = 1'b1;

    // packet kinds
    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END_ACK = 2'd2;

endpackage

FILE: hw/rtl/srrw_ram.sv
// generic single write port ram with registered read
module srrw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/selective_repeat_receive_window.sv
// top level of the selective-repeat receive window
//
// receiver side of a selective-repeat window. a packet descriptor is taken on
// a rising edge with start high and busy low. start packets, packets that
// failed their checks and everything after an end packet cause no result and
// leave busy low. an end packet gives one end ack in the next cycle and also
// leaves busy low. after the transfer of a data packet busy is high while it
// is worked on: the window compare alone when it lies outside the window
// (no result); window compare, slot write and data ack when it lands ahead
// of next expected; and when it fills the slot at next expected and n slots
// are released in order, window compare, slot write, then map check with ram
// read and deliver for every released slot, a closing map check, then the
// data ack, with at most WINDOW slots released. the registered read of the
// slot ram is why each release takes a map check and a deliver step. each
// result is on the result ports for one cycle marked by strobe and cannot be
// held off; the last result of a packet has last set. writing start_seq
// reloads next expected, head, slot map and end flag: slots are counted from
// the new start
module selective_repeat_receive_window #(
    parameter int unsigned WINDOW = srrw_pkg::WINDOW_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command side
    input  logic                             start,
    output logic                             busy,
    input  logic [srrw_pkg::MODE_W-1:0]      mode,
    input  logic [srrw_pkg::SEQ_W-1:0]       seq_num,
    input  logic [srrw_pkg::LEN_W-1:0]       payload_len,
    input  logic                             intact,
    input  logic [srrw_pkg::REF_W-1:0]       payload_ref,
    // result side
    output logic                             strobe,
    output logic [srrw_pkg::KIND_W-1:0]      kind,
    output logic [srrw_pkg::SEQ_W-1:0]       number,
    output logic [srrw_pkg::LEN_W-1:0]       out_len,
    output logic [srrw_pkg::REF_W-1:0]       out_ref,
    output logic                             last,
    // configuration
    input  logic                             wr_en,
    input  logic [srrw_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [srrw_pkg::CFG_DATA_W-1:0]  wr_data
);

    // slot index and window count widths
    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned W_BITS = $clog2(WINDOW + 1);
    localparam int unsigned CNT_W = (W_BITS > 5) ? W_BITS : 5;
    localparam int unsigned RAM_W = srrw_pkg::LEN_W + srrw_pkg::REF_W;
    localparam logic [15:0] MAX_PAYLOAD_16 = 16'(srrw_pkg::MAX_PAYLOAD);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_CHECK   = 6'b000010,
        S_WRITE   = 6'b000100,
        S_READ    = 6'b001000,
        S_DELIVER = 6'b010000,
        S_ACK     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // window state
    logic [srrw_pkg::SEQ_W-1:0]   next_exp_reg, next_exp_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [WINDOW-1:0]            map_reg, map_next;
    logic                         fin_reg, fin_next;
    logic [srrw_pkg::WSIZE_W-1:0] wsize_reg, wsize_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;

    // latched packet
    logic [srrw_pkg::SEQ_W-1:0]   seq_reg, seq_next;
    logic [srrw_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [srrw_pkg::REF_W-1:0]   ref_reg, ref_next;
    logic [IDX_W:0]               off_reg, off_next;

    // result registers
    logic                         strobe_reg, strobe_next;
    logic [srrw_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [srrw_pkg::SEQ_W-1:0]   number_reg, number_next;
    logic [srrw_pkg::LEN_W-1:0]   out_len_reg, out_len_next;
    logic [srrw_pkg::REF_W-1:0]   out_ref_reg, out_ref_next;
    logic                         last_reg, last_next;

    // working signals
    logic [W_BITS-1:0]            w_eff;
    logic [srrw_pkg::SEQ_W-1:0]   off_full;
    logic [IDX_W:0]               slot_sum;
    logic [IDX_W-1:0]             slot;
    logic [IDX_W-1:0]             head_inc;
    logic [srrw_pkg::LEN_W-1:0]   len_sat;
    logic                         ram_we;
    logic                         ram_re;
    logic [RAM_W-1:0]             ram_rdata;

    // effective window: zero acts as one, anything above WINDOW as WINDOW
    always_comb
    begin
        if (wsize_reg == '0)
        begin
            w_eff = W_BITS'(1);
        end
        else if (32'(wsize_reg) > WINDOW)
        begin
            w_eff = W_BITS'(WINDOW);
        end
        else
        begin
            w_eff = W_BITS'(wsize_reg);
        end
    end

    // distance from next expected, modulo 2^32
    assign off_full = seq_reg - next_exp_reg;

    // circular slot of the packet: head + offset, one subtract to wrap
    assign slot_sum = {1'b0, head_reg} + off_reg;
    assign slot = (slot_sum >= (IDX_W + 1)'(WINDOW)) ?
                  IDX_W'(slot_sum - (IDX_W + 1)'(WINDOW)) : IDX_W'(slot_sum);

    assign head_inc = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;

    // payload length saturation
    assign len_sat = ({5'b0, payload_len} > MAX_PAYLOAD_16) ?
                     srrw_pkg::LEN_W'(MAX_PAYLOAD_16) : payload_len;

    srrw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata ({len_reg, ref_reg}),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        next_exp_next = next_exp_reg;
        head_next     = head_reg;
        map_next      = map_reg;
        fin_next      = fin_reg;
        wsize_next    = wsize_reg;
        cnt_next      = cnt_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        ref_next      = ref_reg;
        off_next      = off_reg;
        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        number_next   = number_reg;
        out_len_next  = out_len_reg;
        out_ref_next  = out_ref_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // ignored items finish here with no result
                if (start && !fin_reg && intact && (mode != srrw_pkg::MODE_START))
                begin
                    if (mode == srrw_pkg::MODE_END)
                    begin
                        strobe_next  = 1'b1;
                        kind_next    = srrw_pkg::KIND_END_ACK;
                        number_next  = seq_num;
                        out_len_next = '0;
                        out_ref_next = '0;
                        last_next    = 1'b1;
                        fin_next     = 1'b1;
                    end
                    else
                    begin
                        // data, and the unused code taken as data
                        seq_next   = seq_num;
                        len_next   = len_sat;
                        ref_next   = payload_ref;
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                // outside the window, old duplicates too: dropped silently
                if (off_full < 32'(w_eff))
                begin
                    off_next   = off_full[IDX_W:0];
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_WRITE:
            begin
                ram_we         = 1'b1;
                map_next[slot] = 1'b1;
                cnt_next       = '0;
                if (off_reg == '0)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_ACK;
                end
            end

            S_READ:
            begin
                if ((cnt_reg < CNT_W'(w_eff)) && map_reg[head_reg])
                begin
                    ram_re     = 1'b1;
                    state_next = S_DELIVER;
                end
                else
                begin
                    state_next = S_ACK;
                end
            end

            S_DELIVER:
            begin
                strobe_next        = 1'b1;
                kind_next          = srrw_pkg::KIND_DELIVER;
                number_next        = next_exp_reg;
                out_len_next       = ram_rdata[RAM_W-1:srrw_pkg::REF_W];
                out_ref_next       = ram_rdata[srrw_pkg::REF_W-1:0];
                last_next          = 1'b0;
                map_next[head_reg] = 1'b0;
                next_exp_next      = next_exp_reg + 1'b1;
                head_next          = head_inc;
                cnt_next           = cnt_reg + 1'b1;
                state_next         = S_READ;
            end

            S_ACK:
            begin
                strobe_next  = 1'b1;
                kind_next    = srrw_pkg::KIND_ACK;
                number_next  = next_exp_reg;
                out_len_next = '0;
                out_ref_next = '0;
                last_next    = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes: the user writes only ever while idle; the block does not enforce it
        if (wr_en)
        begin
            unique case (wr_index)
                srrw_pkg::REG_WINDOW_SIZE:
                begin
                    wsize_next = wr_data[srrw_pkg::WSIZE_W-1:0];
                end
                srrw_pkg::REG_START_SEQ:
                begin
                    // slots are only ever addressed relative to head, so the
                    // new connection simply starts counting from slot zero
                    next_exp_next = wr_data[srrw_pkg::SEQ_W-1:0];
                    head_next     = '0;
                    map_next      = '0;
                    fin_next      = 1'b0;
                end
                default:
                begin
                    wsize_next = wsize_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            next_exp_reg <= '0;
            head_reg     <= '0;
            map_reg      <= '0;
            fin_reg      <= 1'b0;
            wsize_reg    <= srrw_pkg::WSIZE_RESET;
            cnt_reg      <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            next_exp_reg <= next_exp_next;
            head_reg     <= head_next;
            map_reg      <= map_next;
            fin_reg      <= fin_next;
            wsize_reg    <= wsize_next;
            cnt_reg      <= cnt_next;
            strobe_reg   <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        seq_reg     <= seq_next;
        len_reg     <= len_next;
        ref_reg     <= ref_next;
        off_reg     <= off_next;
        kind_reg    <= kind_next;
        number_reg  <= number_next;
        out_len_reg <= out_len_next;
        out_ref_reg <= out_ref_next;
        last_reg    <= last_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign kind    = kind_reg;
    assign number  = number_reg;
    assign out_len = out_len_reg;
    assign out_ref = out_ref_reg;
    assign last    = last_reg;

endmodule
